@@ rtl/bpd_pkg.sv @@
package bpd_pkg;

	localparam logic [7:0] TOK_FIRST = 8'h80;
	localparam logic [7:0] TOK_LAST  = 8'hCB;
	localparam logic [7:0] TOK_PI    = 8'hFF;
	localparam logic [7:0] UPPER_LO  = 8'hC1;
	localparam logic [7:0] UPPER_HI  = 8'hDA;
	localparam logic [7:0] CH_A      = 8'h41;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_NL     = 8'h0A;

	localparam int KW_COUNT = 76;

	// right-justified, zero padded
	localparam logic [63:0] KW_ROM [KW_COUNT] = '{
		64'("END"), 64'("FOR"), 64'("NEXT"), 64'("DATA"),
		64'("INPUT#"), 64'("INPUT"), 64'("DIM"), 64'("READ"),
		64'("LET"), 64'("GOTO"), 64'("RUN"), 64'("IF"),
		64'("RESTORE"), 64'("GOSUB"), 64'("RETURN"), 64'("REM"),
		64'("STOP"), 64'("ON"), 64'("WAIT"), 64'("LOAD"),
		64'("SAVE"), 64'("VERIFY"), 64'("DEF"), 64'("POKE"),
		64'("PRINT#"), 64'("PRINT"), 64'("CONT"), 64'("LIST"),
		64'("CLR"), 64'("CMD"), 64'("SYS"), 64'("OPEN"),
		64'("CLOSE"), 64'("GET"), 64'("NEW"), 64'("TAB("),
		64'("TO"), 64'("FN"), 64'("SPC("), 64'("THEN"),
		64'("NOT"), 64'("STEP"), 64'("+"), 64'("-"),
		64'("*"), 64'("/"), 64'("^"), 64'("AND"),
		64'("OR"), 64'(">"), 64'("="), 64'("<"),
		64'("SGN"), 64'("INT"), 64'("ABS"), 64'("USR"),
		64'("FRE"), 64'("POS"), 64'("SQR"), 64'("RND"),
		64'("LOG"), 64'("EXP"), 64'("COS"), 64'("SIN"),
		64'("TAN"), 64'("ATN"), 64'("PEEK"), 64'("LEN"),
		64'("STR$"), 64'("VAL"), 64'("ASC"), 64'("CHR$"),
		64'("LEFT$"), 64'("RIGHT$"), 64'("MID$"), 64'("GO")
	};

	localparam logic [63:0] PI_TEXT = 64'("{PI}");

	typedef enum logic [1:0] {
		J_STATUS = 2'd0,
		J_TEXT   = 2'd1,
		J_NUM    = 2'd2
	} job_kind_t;

	typedef struct packed {
		job_kind_t   kind;
		logic [63:0] text;
		logic [2:0]  len;
		logic [15:0] num;
		logic [2:0]  top_pos;
		logic        nl;
		logic        fin;
		logic        err;
	} job_t;

	function automatic logic [2:0] kw_len(input logic [63:0] t);
		logic [3:0] n;
		n = '0;
		for (int i = 0; i < 8; i++) begin
			if (t[i*8 +: 8] != 8'h00)
				n = n + 4'd1;
		end
		return n[2:0];
	endfunction

	function automatic logic [16:0] dec_pow(input logic [2:0] k);
		logic [16:0] p;
		case (k)
			3'd0: p = 17'd1;
			3'd1: p = 17'd10;
			3'd2: p = 17'd100;
			3'd3: p = 17'd1000;
			3'd4: p = 17'd10000;
			default: p = 17'd1;
		endcase
		return p;
	endfunction

	function automatic logic [2:0] dec_top_pos(input logic [15:0] v);
		logic [2:0] p;
		if (v >= 16'd10000)
			p = 3'd4;
		else if (v >= 16'd1000)
			p = 3'd3;
		else if (v >= 16'd100)
			p = 3'd2;
		else if (v >= 16'd10)
			p = 3'd1;
		else
			p = 3'd0;
		return p;
	endfunction

	// one decimal digit at position k: {digit, remainder}
	function automatic logic [19:0] dec_step(input logic [15:0] v, input logic [2:0] k);
		logic [16:0] p;
		logic [16:0] thr;
		logic [16:0] sub;
		logic [3:0]  d;
		p   = dec_pow(k);
		sub = '0;
		d   = '0;
		for (int i = 1; i < 10; i++) begin
			thr = 17'(i * p);
			if ({1'b0, v} >= thr) begin
				d   = 4'(i);
				sub = thr;
			end
		end
		return {d, 16'({1'b0, v} - sub)};
	endfunction

endpackage

@@ rtl/basic_program_detokenizer.sv @@
// Channel   Signals                                         Dir  Handshake
// byte      in_byte, final_byte                             in   byte_valid / byte_stall
// result    text_char, char_valid, run_last, finished,      out  result_valid / result_stall
//           status
//
// Each byte is taken when the queue has room and yields 0 to 7 result transactions,
// one per cycle from the back end while result_stall is low, a whole job before the next.
// Line numbers are printed one decimal digit per unstalled cycle by compare-and-subtract.
// byte_stall rises only when the QUEUE_DEPTH-entry job queue is full.
// Reset returns to expecting a link low byte with quote mode clear; no clearing pass.
// After the image completes, further bytes are taken and give no results until reset.
module basic_program_detokenizer #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_stall,
	input  logic [7:0] in_byte,
	input  logic       final_byte,
	output logic       result_valid,
	input  logic       result_stall,
	output logic [7:0] text_char,
	output logic       char_valid,
	output logic       run_last,
	output logic       finished,
	output logic       status
);
	import bpd_pkg::*;

	job_t push_job;
	job_t head_job;
	logic push, pop, q_full, head_valid;

	bpd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.in_byte    (in_byte),
		.final_byte (final_byte),
		.q_full     (q_full),
		.push       (push),
		.job        (push_job)
	);

	bpd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	bpd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_job     (head_job),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.text_char    (text_char),
		.char_valid   (char_valid),
		.run_last     (run_last),
		.finished     (finished),
		.status       (status)
	);

endmodule

@@ rtl/bpd_front.sv @@
module bpd_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          byte_valid,
	output logic          byte_stall,
	input  logic [7:0]    in_byte,
	input  logic          final_byte,
	input  logic          q_full,
	output logic          push,
	output bpd_pkg::job_t job
);
	import bpd_pkg::*;

	typedef enum logic [5:0] {
		PH_LINK_LO = 6'b000001,
		PH_LINK_HI = 6'b000010,
		PH_NUM_LO  = 6'b000100,
		PH_NUM_HI  = 6'b001000,
		PH_BODY    = 6'b010000,
		PH_DONE    = 6'b100000
	} phase_t;

	phase_t      phase_q, phase_nx;
	logic        quote_q, quote_nx;
	logic [7:0]  link_lo_q;
	logic [7:0]  num_lo_q;
	logic        acc;
	logic [63:0] b_text;
	logic [2:0]  b_len;
	logic        b_toggle;
	logic [15:0] num;

	assign byte_stall = q_full;
	assign acc        = byte_valid && !q_full;
	assign num        = {in_byte, num_lo_q};

	always_comb begin
		b_text   = '0;
		b_len    = '0;
		b_toggle = 1'b0;
		if (in_byte == CH_QUOTE) begin
			b_text   = 64'(in_byte);
			b_len    = 3'd1;
			b_toggle = 1'b1;
		end else if (!quote_q && in_byte >= TOK_FIRST) begin
			if (in_byte == TOK_PI) begin
				b_text = PI_TEXT;
				b_len  = 3'd4;
			end else if (in_byte <= TOK_LAST) begin
				b_text = KW_ROM[7'(in_byte - TOK_FIRST)];
				b_len  = kw_len(KW_ROM[7'(in_byte - TOK_FIRST)]);
			end
		end else if (in_byte inside {[UPPER_LO:UPPER_HI]}) begin
			b_text = 64'(8'(in_byte - UPPER_LO + CH_A));
			b_len  = 3'd1;
		end else begin
			b_text = 64'(in_byte);
			b_len  = 3'd1;
		end
	end

	always_comb begin
		phase_nx = phase_q;
		quote_nx = quote_q;
		push     = 1'b0;
		job      = '0;
		job.kind = J_STATUS;
		case (phase_q)
			PH_LINK_LO: begin
				if (final_byte) begin
					push     = acc;
					job.fin  = 1'b1;
					phase_nx = PH_DONE;
				end else begin
					phase_nx = PH_LINK_HI;
				end
			end
			PH_LINK_HI: begin
				if ((link_lo_q | in_byte) == 8'h00) begin
					push     = acc;
					job.fin  = 1'b1;
					phase_nx = PH_DONE;
				end else if (final_byte) begin
					push     = acc;
					job.fin  = 1'b1;
					job.err  = 1'b1;
					phase_nx = PH_DONE;
				end else begin
					phase_nx = PH_NUM_LO;
				end
			end
			PH_NUM_LO: begin
				if (final_byte) begin
					push     = acc;
					job.fin  = 1'b1;
					job.err  = 1'b1;
					phase_nx = PH_DONE;
				end else begin
					phase_nx = PH_NUM_HI;
				end
			end
			PH_NUM_HI: begin
				push        = acc;
				job.kind    = J_NUM;
				job.num     = num;
				job.top_pos = dec_top_pos(num);
				job.nl      = final_byte;
				job.fin     = final_byte;
				quote_nx    = 1'b0;
				phase_nx    = final_byte ? PH_DONE : PH_BODY;
			end
			PH_BODY: begin
				job.kind = J_TEXT;
				if (in_byte == 8'h00) begin
					push     = acc;
					job.nl   = 1'b1;
					job.fin  = final_byte;
					quote_nx = 1'b0;
					phase_nx = final_byte ? PH_DONE : PH_LINK_LO;
				end else begin
					push     = acc && (b_len != 3'd0 || final_byte);
					job.text = b_text;
					job.len  = b_len;
					job.nl   = final_byte && (b_len != 3'd7);
					job.fin  = final_byte;
					quote_nx = quote_q ^ b_toggle;
					if (final_byte)
						phase_nx = PH_DONE;
				end
			end
			PH_DONE: begin
				phase_nx = PH_DONE;
			end
			default: begin
				phase_nx = PH_DONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_LINK_LO;
			quote_q   <= 1'b0;
			link_lo_q <= '0;
			num_lo_q  <= '0;
		end else if (acc) begin
			phase_q <= phase_nx;
			quote_q <= quote_nx;
			if (phase_q == PH_LINK_LO)
				link_lo_q <= in_byte;
			if (phase_q == PH_NUM_LO)
				num_lo_q <= in_byte;
		end
	end

endmodule

@@ rtl/bpd_queue.sv @@
module bpd_queue #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  bpd_pkg::job_t push_job,
	input  logic          pop,
	output logic          full,
	output logic          head_valid,
	output bpd_pkg::job_t head_job
);
	import bpd_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = mem_q[rd_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push)
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : AW'(wr_q + 1'b1);
			if (do_pop)
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : AW'(rd_q + 1'b1);
			if (do_push && !do_pop)
				count_q <= CW'(count_q + 1'b1);
			else if (do_pop && !do_push)
				count_q <= CW'(count_q - 1'b1);
		end
	end

endmodule

@@ rtl/bpd_back.sv @@
module bpd_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_valid,
	input  bpd_pkg::job_t head_job,
	output logic          pop,
	output logic          result_valid,
	input  logic          result_stall,
	output logic [7:0]    text_char,
	output logic          char_valid,
	output logic          run_last,
	output logic          finished,
	output logic          status
);
	import bpd_pkg::*;

	logic [2:0]  idx_q;
	logic [15:0] rem_q;
	logic        res_valid_q;
	logic [7:0]  text_char_q;
	logic        char_valid_q, run_last_q, finished_q, status_q;

	logic        adv;
	logic        last;
	logic        cv;
	logic [7:0]  ch;
	logic [15:0] v;
	logic [2:0]  k;
	logic [2:0]  sel;
	logic [3:0]  dig;
	logic [15:0] rem_nx;
	logic        dig_step;

	assign adv = head_valid && (!res_valid_q || !result_stall);
	assign pop = adv && last;

	assign v             = (idx_q == 3'd0) ? head_job.num : rem_q;
	assign k             = 3'(head_job.top_pos - idx_q);
	assign sel           = 3'(head_job.len - 3'd1 - idx_q);
	assign {dig, rem_nx} = dec_step(v, k);

	always_comb begin
		ch       = CH_NL;
		cv       = 1'b1;
		last     = 1'b1;
		dig_step = 1'b0;
		case (head_job.kind)
			J_STATUS: begin
				ch = 8'h00;
				cv = 1'b0;
			end
			J_TEXT: begin
				if (idx_q < head_job.len) begin
					ch   = head_job.text[{sel, 3'b000} +: 8];
					last = !head_job.nl && (idx_q == 3'(head_job.len - 3'd1));
				end
			end
			J_NUM: begin
				if (idx_q <= head_job.top_pos) begin
					ch       = 8'(CH_0 + {4'b0000, dig});
					last     = 1'b0;
					dig_step = 1'b1;
				end else if (idx_q == 3'(head_job.top_pos + 3'd1)) begin
					ch   = CH_SPACE;
					last = !head_job.nl;
				end
			end
			default: begin
				ch = 8'h00;
				cv = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				res_valid_q <= 1'b1;
				idx_q       <= last ? 3'd0 : 3'(idx_q + 3'd1);
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			text_char_q  <= ch;
			char_valid_q <= cv;
			run_last_q   <= last;
			finished_q   <= last && head_job.fin;
			status_q     <= last && head_job.fin && head_job.err;
			if (dig_step)
				rem_q <= rem_nx;
		end
	end

	assign result_valid = res_valid_q;
	assign text_char    = text_char_q;
	assign char_valid   = char_valid_q;
	assign run_last     = run_last_q;
	assign finished     = finished_q;
	assign status       = status_q;

endmodule
